// ===== sv/sbbl_pkg.sv =====
package sbbl_pkg;

  localparam int POS_W  = 16;
  localparam int TAG_W  = 8;
  localparam int IDX_W  = 4;
  localparam int FRAC_W = 17;
  localparam int CNT_W  = 5;
  localparam int THR_W  = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

endpackage

// ===== sv/sorted_breakpoint_blend_lookup.sv =====
// Sorted breakpoint table with bracket lookup.
// Input words arrive on in_tvalid/in_tready; in_tuser carries the action (insert, remove,
// clear, lookup) and in_tdata the position, clip tag and entry index. Every word gives
// exactly one result word on out_tvalid/out_tready, with the status in out_tuser.
// The entries live in a row of cells. Insert, remove and clear finish in the cycle the word
// is accepted; the result then passes through the done state into the output register. A
// lookup rotates the whole row once past the head pair, then chooses the bracket in the
// evaluate state and, when a fraction is needed, runs the bit-serial divider. One word is
// in work at a time; in_tready is high only while the block is idle, so a new word is taken
// only once the result of the last one has been loaded into the output register.
// The result sits in an output register: if the receiver stalls, the finished word waits
// there; the block may take one more word, but holds its result and takes no further input
// until that register can be loaded.
// span_threshold is written on cfg_valid/cfg_ready (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the table and clears the threshold; no clearing pass is needed, since only
// entries below the fill count are ever read.
module sorted_breakpoint_blend_lookup import sbbl_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // position[15:0], clip_tag[23:16], entry_index[27:24]
  input  logic [1:0]  in_tuser,  // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // lower_index[3:0], upper_index[7:4], lower_tag[15:8], upper_tag[23:16],
  // blend_fraction[40:24], entry_count[45:41]
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser, // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = $clog2(ENTRIES);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]           count_r;
  logic [THR_W-1:0]        thr_r;
  logic [KW-1:0]           k_r;
  logic signed [POS_W-1:0] key_r;
  logic                    found_r;
  logic [KW-1:0]           lo_r;
  logic [POS_W-1:0]        span_r;
  logic [POS_W-1:0]        d_r;
  logic [TAG_W-1:0]        lotag_r, hitag_r;
  logic signed [POS_W-1:0] first_pos_r;
  logic [TAG_W-1:0]        first_tag_r, last_tag_r;

  status_t           res_status_r;
  logic [IDX_W-1:0]  res_lo_r, res_hi_r;
  logic [TAG_W-1:0]  res_lotag_r, res_hitag_r;
  logic [FRAC_W-1:0] res_frac_r;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  logic signed [POS_W-1:0] in_pos;
  logic [TAG_W-1:0]        in_tag;
  logic [IDX_W-1:0]        in_idx;
  action_t                 act;
  logic                    in_acc, full, acc_ins, acc_rem, scan_rot, frac_ok, div_start;
  logic                    out_free, div_done;
  logic [FRAC_W-1:0]       div_quot;
  logic [XW-1:0]           count_x, idx_x, k_x;

  logic signed [POS_W-1:0] pos_w [ENTRIES];
  logic [TAG_W-1:0]        tag_w [ENTRIES];
  logic                    gt_w  [ENTRIES];
  logic                    gtv_w [ENTRIES];

  logic                    pair_ok, pair_hit;
  logic [POS_W:0]          span_full, d_full;

  assign in_pos  = in_tdata[15:0];
  assign in_tag  = in_tdata[23:16];
  assign in_idx  = in_tdata[27:24];
  assign act     = action_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;
  assign count_x = XW'(count_r);
  assign idx_x   = XW'(in_idx);
  assign k_x     = XW'(k_r);
  assign full    = count_r == CW'(ENTRIES);
  assign acc_ins = in_acc && (act == ACT_INSERT) && !full;
  assign acc_rem = in_acc && (act == ACT_REMOVE) && (idx_x < count_x);
  assign out_free = !out_tvalid_r || out_tready;
  assign frac_ok  = found_r && (span_r > thr_r) && (span_r != '0);

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      cell_op_t op;
      logic     valid;
      logic     prev_gt;
      logic     self_at;

      assign valid      = XW'(gi) < count_x;
      assign gtv_w[gi]  = valid && gt_w[gi];
      assign self_at    = gtv_w[gi] || (XW'(gi) == count_x);

      if (gi == 0) begin : g_first
        assign prev_gt = 1'b0;
      end else begin : g_rest
        assign prev_gt = gtv_w[gi-1];
      end

      always_comb begin
        op = CELL_HOLD;
        if (scan_rot) begin
          op = CELL_FROM_NEXT;
        end else if (acc_ins) begin
          if (prev_gt) begin
            op = CELL_FROM_PREV;
          end else if (self_at) begin
            op = CELL_LOAD_NEW;
          end
        end else if (acc_rem && (XW'(gi) >= idx_x) && (XW'(gi + 1) < count_x)) begin
          op = CELL_FROM_NEXT;
        end
      end

      sbbl_cell u_cell (
        .clk      (clk),
        .op       (op),
        .key      (in_pos),
        .new_pos  (in_pos),
        .new_tag  (in_tag),
        .prev_pos (pos_w[(gi + ENTRIES - 1) % ENTRIES]),
        .prev_tag (tag_w[(gi + ENTRIES - 1) % ENTRIES]),
        .next_pos (pos_w[(gi + 1) % ENTRIES]),
        .next_tag (tag_w[(gi + 1) % ENTRIES]),
        .pos      (pos_w[gi]),
        .tag      (tag_w[gi]),
        .gt       (gt_w[gi])
      );
    end
  endgenerate

  // During the scan the head pair of the row holds entries k and k+1.
  assign pair_ok   = (k_x + XW'(1)) < count_x;
  assign pair_hit  = pair_ok && (pos_w[0] <= key_r) && (key_r <= pos_w[1]);
  assign span_full = {pos_w[1][POS_W-1], pos_w[1]} - {pos_w[0][POS_W-1], pos_w[0]};
  assign d_full    = {key_r[POS_W-1], key_r} - {pos_w[0][POS_W-1], pos_w[0]};

  sbbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (d_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((act == ACT_LOOKUP) && (count_r != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (k_r == KW'(ENTRIES - 1)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (frac_ok) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    scan_rot  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_SCAN:  scan_rot  = 1'b1;
      S_EVAL:  div_start = frac_ok;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      thr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (in_acc) begin
        case (act)
          ACT_INSERT: begin
            if (!full) begin
              count_r <= count_r + CW'(1);
            end
          end
          ACT_REMOVE: begin
            if (acc_rem) begin
              count_r <= count_r - CW'(1);
            end
          end
          ACT_CLEAR: count_r <= '0;
          default: begin
            count_r <= count_r;
          end
        endcase
      end
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_lo_r    <= '0;
      res_hi_r    <= '0;
      res_lotag_r <= '0;
      res_hitag_r <= '0;
      res_frac_r  <= '0;
      key_r       <= in_pos;
      found_r     <= 1'b0;
      k_r         <= '0;
      case (act)
        ACT_INSERT: res_status_r <= full ? STAT_FULL : STAT_OK;
        ACT_REMOVE: res_status_r <= acc_rem ? STAT_OK : STAT_RANGE;
        ACT_CLEAR:  res_status_r <= STAT_OK;
        default: begin
          res_status_r <= (count_r == '0) ? STAT_EMPTY : STAT_OK;
        end
      endcase
    end
    if (state_r == S_SCAN) begin
      k_r <= k_r + KW'(1);
      if (k_r == '0) begin
        first_pos_r <= pos_w[0];
        first_tag_r <= tag_w[0];
      end
      if ((k_x + XW'(1)) == count_x) begin
        last_tag_r <= tag_w[0];
      end
      if (pair_hit && !found_r) begin
        found_r <= 1'b1;
        lo_r    <= k_r;
        span_r  <= span_full[POS_W-1:0];
        d_r     <= d_full[POS_W-1:0];
        lotag_r <= tag_w[0];
        hitag_r <= tag_w[1];
      end
    end
    if (state_r == S_EVAL) begin
      if (found_r) begin
        res_lo_r    <= IDX_W'(lo_r);
        res_hi_r    <= IDX_W'(lo_r) + IDX_W'(1);
        res_lotag_r <= lotag_r;
        res_hitag_r <= hitag_r;
      end else if (key_r < first_pos_r) begin
        res_lo_r    <= '0;
        res_hi_r    <= '0;
        res_lotag_r <= first_tag_r;
        res_hitag_r <= first_tag_r;
      end else begin
        res_lo_r    <= IDX_W'(count_r - CW'(1));
        res_hi_r    <= IDX_W'(count_r - CW'(1));
        res_lotag_r <= last_tag_r;
        res_hitag_r <= last_tag_r;
      end
    end
    if ((state_r == S_DIV) && div_done) begin
      res_frac_r <= div_quot;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= {2'b00, CNT_W'(count_r), res_frac_r, res_hitag_r, res_lotag_r,
                      res_hi_r, res_lo_r};
      out_tuser_r <= res_status_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("fill count exceeds table depth");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (act == ACT_LOOKUP) && (count_r != '0)) |=> state_r == S_SCAN)
    else $error("lookup on a filled table did not start a scan");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (res_status_r == STAT_FULL)) |-> count_r == CW'(ENTRIES))
    else $error("table-full status with room left");

  a_frac_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STAT_OK)) |-> out_tdata[40:24] == '0)
    else $error("non-zero fraction on an error word");
`endif

endmodule

// ===== sv/sbbl_cell.sv =====
module sbbl_cell import sbbl_pkg::*; (
  input  logic                    clk,
  input  cell_op_t                op,
  input  logic signed [POS_W-1:0] key,
  input  logic signed [POS_W-1:0] new_pos,
  input  logic        [TAG_W-1:0] new_tag,
  input  logic signed [POS_W-1:0] prev_pos,
  input  logic        [TAG_W-1:0] prev_tag,
  input  logic signed [POS_W-1:0] next_pos,
  input  logic        [TAG_W-1:0] next_tag,
  output logic signed [POS_W-1:0] pos,
  output logic        [TAG_W-1:0] tag,
  output logic                    gt
);

  logic signed [POS_W-1:0] pos_r;
  logic        [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD_NEW: begin
        pos_r <= new_pos;
        tag_r <= new_tag;
      end
      CELL_FROM_PREV: begin
        pos_r <= prev_pos;
        tag_r <= prev_tag;
      end
      CELL_FROM_NEXT: begin
        pos_r <= next_pos;
        tag_r <= next_tag;
      end
      default: begin
        pos_r <= pos_r;
        tag_r <= tag_r;
      end
    endcase
  end

  assign pos = pos_r;
  assign tag = tag_r;
  // The insertion point is the first held entry that lies strictly above the new position.
  assign gt  = pos_r > key;

endmodule

// ===== sv/sbbl_div.sv =====
module sbbl_div import sbbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [POS_W-1:0]  num,
  input  logic [POS_W-1:0]  den,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  // Restoring division of num * 2^16 by den, one quotient bit a cycle, num not above den.
  logic [FRAC_W-1:0] rem_r;
  logic [FRAC_W-1:0] quot_r;
  logic [POS_W-1:0]  den_r;
  logic [CNT_W-1:0]  step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;
  logic [FRAC_W-1:0] diff;
  logic [FRAC_W-1:0] rem_nxt;

  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = rem_r - {1'b0, den_r};

  always_comb begin
    if (ge) begin
      rem_nxt = {diff[FRAC_W-2:0], 1'b0};
    end else begin
      rem_nxt = {rem_r[FRAC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= CNT_W'(FRAC_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - CNT_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== tb/breakpoint_result_checker.sv =====
module breakpoint_result_checker import sbbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,  // position[15:0], clip_tag[23:16], entry_index[27:24]
  input  logic [1:0]  in_tuser,  // action[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  // lower_index[3:0], upper_index[7:4], lower_tag[15:8], upper_tag[23:16],
  // blend_fraction[40:24], entry_count[45:41]
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser, // status[1:0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  localparam int DEPTH = 16;

  typedef struct {
    status_t           status;
    logic [IDX_W-1:0]  lower_index;
    logic [IDX_W-1:0]  upper_index;
    logic [TAG_W-1:0]  lower_tag;
    logic [TAG_W-1:0]  upper_tag;
    logic [FRAC_W-1:0] blend_fraction;
    logic [CNT_W-1:0]  entry_count;
  } blend_result_t;

  // Shadow copy of the breakpoint table and the threshold register.
  logic signed [POS_W-1:0] shadow_pos [DEPTH];
  logic [TAG_W-1:0]        shadow_tag [DEPTH];
  int unsigned             shadow_fill;
  logic [THR_W-1:0]        shadow_threshold;

  blend_result_t awaited_results [$];
  int unsigned   results_checked;

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch in result word %0d: %s is %0d, expected %0d",
             results_checked, field, got, want);
  endtask

  task automatic predict_bracket(input action_t act, input logic signed [POS_W-1:0] p,
                                 input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] idx,
                                 output blend_result_t r);
    int     at;
    int     k;
    int     lo_pos;
    int     hi_pos;
    int     span;
    longint num;
    bit     found;
    r.status         = STAT_OK;
    r.lower_index    = '0;
    r.upper_index    = '0;
    r.lower_tag      = '0;
    r.upper_tag      = '0;
    r.blend_fraction = '0;
    found            = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // Equal positions stay ahead of the new entry.
          at = shadow_fill;
          while (at > 0 && shadow_pos[at-1] > p) begin
            shadow_pos[at] = shadow_pos[at-1];
            shadow_tag[at] = shadow_tag[at-1];
            at--;
          end
          shadow_pos[at] = p;
          shadow_tag[at] = tag;
          shadow_fill++;
        end
      end
      ACT_REMOVE: begin
        if (idx >= shadow_fill) begin
          r.status = STAT_RANGE;
        end else begin
          for (k = idx; k + 1 < shadow_fill; k++) begin
            shadow_pos[k] = shadow_pos[k+1];
            shadow_tag[k] = shadow_tag[k+1];
          end
          shadow_fill--;
        end
      end
      ACT_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (k = 0; k + 1 < shadow_fill && !found; k++) begin
            lo_pos = shadow_pos[k];
            hi_pos = shadow_pos[k+1];
            if (int'(p) >= lo_pos && int'(p) <= hi_pos) begin
              found         = 1'b1;
              span          = hi_pos - lo_pos;
              r.lower_index = IDX_W'(k);
              r.upper_index = IDX_W'(k + 1);
              if (span > int'(shadow_threshold) && span != 0) begin
                num              = longint'(int'(p) - lo_pos) << 16;
                r.blend_fraction = FRAC_W'(num / span);
              end
            end
          end
          if (!found) begin
            if (p < shadow_pos[0]) begin
              r.lower_index = '0;
              r.upper_index = '0;
            end else begin
              r.lower_index = IDX_W'(shadow_fill - 1);
              r.upper_index = IDX_W'(shadow_fill - 1);
            end
          end
          r.lower_tag = shadow_tag[r.lower_index];
          r.upper_tag = shadow_tag[r.upper_index];
        end
      end
    endcase
    r.entry_count = CNT_W'(shadow_fill);
  endtask

  always @(posedge clk) begin
    blend_result_t got;
    blend_result_t want;
    if (!rst_n) begin
      shadow_fill      = 0;
      shadow_threshold = '0;
      mismatch_count   = 0;
      results_checked  = 0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        shadow_threshold = cfg_data;
      if (out_tvalid && out_tready) begin
        got.status         = status_t'(out_tuser);
        got.lower_index    = out_tdata[3:0];
        got.upper_index    = out_tdata[7:4];
        got.lower_tag      = out_tdata[15:8];
        got.upper_tag      = out_tdata[23:16];
        got.blend_fraction = out_tdata[40:24];
        got.entry_count    = out_tdata[45:41];
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result word, status", got.status, -1);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
          if (got.lower_index !== want.lower_index)
            flag_mismatch("lower_index", got.lower_index, want.lower_index);
          if (got.upper_index !== want.upper_index)
            flag_mismatch("upper_index", got.upper_index, want.upper_index);
          if (got.lower_tag !== want.lower_tag)
            flag_mismatch("lower_tag", got.lower_tag, want.lower_tag);
          if (got.upper_tag !== want.upper_tag)
            flag_mismatch("upper_tag", got.upper_tag, want.upper_tag);
          if (got.blend_fraction !== want.blend_fraction)
            flag_mismatch("blend_fraction", got.blend_fraction, want.blend_fraction);
          if (got.entry_count !== want.entry_count)
            flag_mismatch("entry_count", got.entry_count, want.entry_count);
        end
        results_checked++;
      end
      if (in_tvalid && in_tready) begin
        predict_bracket(action_t'(in_tuser), in_tdata[15:0], in_tdata[23:16],
                        in_tdata[27:24], want);
        awaited_results.insert(awaited_results.size(), want);
      end
      // Registered so that the stimulus sees a settled count after each edge.
      outstanding <= awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sbbl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;  // position[15:0], clip_tag[23:16], entry_index[27:24]
  logic [1:0]  in_tuser;  // action[1:0]
  logic        out_tvalid;
  logic        out_tready;
  // lower_index[3:0], upper_index[7:4], lower_tag[15:8], upper_tag[23:16],
  // blend_fraction[40:24], entry_count[45:41]
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser; // status[1:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_sent;
  int unsigned lookups_sent;
  int unsigned thresholds_written;

  sorted_breakpoint_blend_lookup #(.ENTRIES(16)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  breakpoint_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high from one word to the next unless a gap is drawn, so it is never
  // lowered and raised within the same step.
  task automatic send_word(input action_t act, input logic [15:0] pos,
                           input logic [7:0] tag, input logic [3:0] idx);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, idx, tag, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (act == ACT_LOOKUP)
      lookups_sent++;
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thresholds_written++;
  endtask

  // Mostly clustered positions so that brackets, spans and duplicates occur often.
  function automatic logic [15:0] pick_position;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30)
      return 16'($urandom_range(65535));
    else if (sel < 80)
      return 16'(int'($urandom_range(3000)) - 1500);
    else if (sel < 90)
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    else
      return 16'(256 * $urandom_range(7));
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned burst;
    int unsigned sel;
    int unsigned n;
    // Start from an empty table and fill it, sometimes past capacity.
    send_word(ACT_CLEAR, pick_position(), 8'($urandom), 4'($urandom));
    burst = $urandom_range(18, 2);
    for (n = 0; n < burst; n++)
      send_word(ACT_INSERT, pick_position(), 8'($urandom), 4'($urandom));
    for (n = burst + 1; n < count; n++) begin
      sel = $urandom_range(999);
      if (sel < 400)
        send_word(ACT_INSERT, pick_position(), 8'($urandom), 4'($urandom));
      else if (sel < 820)
        send_word(ACT_LOOKUP, pick_position(), 8'($urandom), 4'($urandom));
      else if (sel < 985)
        send_word(ACT_REMOVE, pick_position(), 8'($urandom), 4'($urandom_range(15)));
      else
        send_word(ACT_CLEAR, pick_position(), 8'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    int unsigned phase;
    logic [15:0] threshold;
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= ACT_INSERT;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    words_sent      = 0;
    lookups_sent    = 0;
    thresholds_written = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset threshold of zero.
    send_word(ACT_LOOKUP, 16'h0000, 8'h00, 4'h0);  // empty table
    send_word(ACT_REMOVE, 16'h0000, 8'h00, 4'h0);  // nothing to remove
    send_word(ACT_INSERT, 16'h8000, 8'h00, 4'h0);
    send_word(ACT_LOOKUP, 16'h7FFF, 8'h00, 4'h0);  // single entry, above it
    send_word(ACT_LOOKUP, 16'h8000, 8'h00, 4'h0);  // single entry, on it
    send_word(ACT_INSERT, 16'h7FFF, 8'hFF, 4'h0);
    send_word(ACT_LOOKUP, 16'h0000, 8'h00, 4'h0);  // widest possible span
    send_word(ACT_LOOKUP, 16'h7FFF, 8'h00, 4'h0);  // full weight
    send_word(ACT_LOOKUP, 16'h8000, 8'h00, 4'h0);
    send_word(ACT_INSERT, 16'h0100, 8'hA5, 4'h0);
    send_word(ACT_INSERT, 16'h0100, 8'h5A, 4'h0);  // equal position goes after
    send_word(ACT_LOOKUP, 16'h0100, 8'h00, 4'h0);
    send_word(ACT_LOOKUP, 16'h012C, 8'h00, 4'h0);
    send_word(ACT_REMOVE, 16'h0000, 8'h00, 4'hF);  // index out of range
    send_word(ACT_REMOVE, 16'h0000, 8'h00, 4'h1);
    send_word(ACT_LOOKUP, 16'h0100, 8'h00, 4'h0);
    send_word(ACT_CLEAR,  16'h0000, 8'h00, 4'h0);
    send_word(ACT_INSERT, 16'h0000, 8'h11, 4'h0);
    send_word(ACT_LOOKUP, 16'hFFFF, 8'h00, 4'h0);  // below the first entry
    send_word(ACT_LOOKUP, 16'h0001, 8'h00, 4'h0);  // above the last entry
    send_word(ACT_INSERT, 16'h0001, 8'h22, 4'h0);
    send_word(ACT_LOOKUP, 16'h0001, 8'h00, 4'h0);
    send_word(ACT_INSERT, 16'h0000, 8'h44, 4'h0);
    send_word(ACT_LOOKUP, 16'h0000, 8'h00, 4'h0);  // zero span bracket
    drain_results;

    for (phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (phase)
        0:       threshold = 16'd0;
        1:       threshold = 16'd255;
        2:       threshold = 16'hFFFF;
        3:       threshold = 16'($urandom);
        4:       threshold = 16'd1;
        default: threshold = 16'($urandom_range(600, 50));
      endcase
      write_threshold(threshold);
      run_random(90);
      drain_results;
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (60) @(posedge clk);
    $display("Sent %0d words, %0d of them lookups, across %0d span threshold settings",
             words_sent, lookups_sent, thresholds_written);
    $display("and four handshake idling modes; %0d field mismatches seen.", mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
